@@ hw/rtl/pressure_temperature_compensation_unit_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the compensation unit
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define PTCU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition in one cycle implies expression in the next
`define PTCU_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define PTCU_ASSERT(lbl, clk, rst_n, prop)
`define PTCU_ASSERT_NEXT(lbl, clk, rst_n, cond, expr)
`endif

`endif

@@ hw/rtl/ptcu_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcu_pkg
// shared types and constants of the compensation unit
// ----------------------------------------------------------------------------
package ptcu_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	// divider: 64-bit dividend, divisor magnitude below 2^31
	localparam int DIV_W = 64;
	localparam int DEN_W = 31;

	typedef struct packed {
		logic signed [15:0] p9;
		logic signed [15:0] p8;
		logic signed [15:0] p7;
		logic signed [15:0] p6;
		logic signed [15:0] p5;
		logic signed [15:0] p4;
		logic signed [15:0] p3;
		logic signed [15:0] p2;
		logic [15:0]        p1;
		logic signed [15:0] t3;
		logic signed [15:0] t2;
		logic [15:0]        t1;
	} calib_t;

	typedef struct packed {
		logic signed [24:0] fine;
		logic signed [14:0] temp;
		logic [19:0]        raw_p;
	} qent_t;

	typedef struct packed {
		logic               neg;
		logic               invalid;
		logic signed [14:0] temp;
	} div_side_t;

endpackage

@@ hw/rtl/ptcu_front.sv @@
// ----------------------------------------------------------------------------
// ptcu_front
// accepts raw samples, computes fine and compensated temperature
// ----------------------------------------------------------------------------
module ptcu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [19:0]      raw_t,
	input  logic [19:0]      raw_p,
	input  ptcu_pkg::calib_t calib,
	input  logic             q_full,
	output logic             push,
	output ptcu_pkg::qent_t  push_data
);
	import ptcu_pkg::*;

	localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX = 15'sd8500;

	logic fe;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [17:0] d1_c, d1_s1;
	logic signed [16:0] d2_c, d2_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4;
	logic signed [34:0] m1_c;
	logic signed [33:0] sq_c;
	logic signed [23:0] a1_s2;
	logic signed [21:0] sq_s2;
	logic signed [37:0] m2_c;
	logic signed [24:0] fine_c, fine_s3, fine_s4;
	logic signed [28:0] tm_c;
	logic signed [20:0] tc_c;
	logic signed [14:0] tsat_c, temp_s4;

	assign fe       = !(vld_s4 && q_full);
	assign in_ready = fe;
	assign push     = vld_s4 && !q_full;
	assign push_data = '{fine: fine_s4, temp: temp_s4, raw_p: rp_s4};

	assign d1_c = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
	assign d2_c = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, calib.t1});
	assign m1_c = d1_s1 * calib.t2;
	assign sq_c = d2_s1 * d2_s1;
	assign m2_c = sq_s2 * calib.t3;
	assign fine_c = a1_s2 + $signed(m2_c[37:14]);
	assign tm_c = fine_s3 * 29'sd5 + 29'sd128;
	assign tc_c = tm_c[28:8];
	assign tsat_c = (tc_c < TEMP_MIN) ? TEMP_MIN :
		((tc_c > TEMP_MAX) ? TEMP_MAX : tc_c[14:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (fe) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			d1_s1   <= d1_c;
			d2_s1   <= d2_c;
			rp_s1   <= raw_p;
			a1_s2   <= m1_c[34:11];
			sq_s2   <= sq_c[33:12];
			rp_s2   <= rp_s1;
			fine_s3 <= fine_c;
			rp_s3   <= rp_s2;
			fine_s4 <= fine_s3;
			temp_s4 <= tsat_c;
			rp_s4   <= rp_s3;
		end
	end

endmodule

@@ hw/rtl/ptcu_queue.sv @@
// ----------------------------------------------------------------------------
// ptcu_queue
// small fifo between the temperature front and the pressure back
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_unit_assert.svh"

module ptcu_queue #(
	parameter int DEPTH = ptcu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ptcu_pkg::qent_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output ptcu_pkg::qent_t head
);
	import ptcu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`PTCU_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`PTCU_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

@@ hw/rtl/ptcu_div.sv @@
// ----------------------------------------------------------------------------
// ptcu_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ptcu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ptcu_pkg::DIV_W-1:0]  in_num,
	input  logic [ptcu_pkg::DEN_W-1:0]  in_den,
	input  ptcu_pkg::div_side_t         in_side,
	output logic                        out_valid,
	output logic [ptcu_pkg::DIV_W-1:0]  out_quot,
	output ptcu_pkg::div_side_t         out_side
);
	import ptcu_pkg::*;

	logic             vld_s  [1:DIV_W];
	logic [DIV_W-1:0] nq_s   [1:DIV_W];
	logic [DEN_W-1:0] rem_s  [1:DIV_W];
	logic [DEN_W-1:0] den_s  [1:DIV_W];
	div_side_t        side_s [1:DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_stage
		logic             vld_in;
		logic [DIV_W-1:0] nq_in;
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		div_side_t        side_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign nq_in   = in_num;
			assign rem_in  = '0;
			assign den_in  = in_den;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k];
			assign nq_in   = nq_s[k];
			assign rem_in  = rem_s[k];
			assign den_in  = den_s[k];
			assign side_in = side_s[k];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_in, nq_in[DIV_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k+1]   <= {nq_in[DIV_W-2:0], ge};
				rem_s[k+1]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				den_s[k+1]  <= den_in;
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_W];
	assign out_quot  = nq_s[DIV_W];
	assign out_side  = side_s[DIV_W];

endmodule

@@ hw/rtl/ptcu_back.sv @@
// ----------------------------------------------------------------------------
// ptcu_back
// pressure datapath: 64-bit wrapping arithmetic, divide, saturate
// ----------------------------------------------------------------------------
module ptcu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ptcu_pkg::calib_t   calib,
	input  logic               q_empty,
	input  ptcu_pkg::qent_t    q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] out_temp,
	output logic [19:0]        out_pa,
	output logic               out_invalid
);
	import ptcu_pkg::*;

	localparam logic signed [26:0] V1_OFS = 27'sd128000;
	localparam logic [20:0]        P_FULL = 21'd1048576;
	localparam logic signed [16:0] K3125  = 17'sd3125;
	localparam logic [63:0]        E_OFS  = 64'h0000_8000_0000_0000;

	// unsigned 32 times signed 17, sign extended to 64
	function automatic logic [63:0] mul_lo(input logic [31:0] x, input logic signed [16:0] y);
		logic signed [49:0] t;
		t = $signed({1'b0, x}) * y;
		return 64'(t);
	endfunction

	// low word of the upper partial product
	function automatic logic [31:0] mul_hi(input logic [31:0] x, input logic signed [16:0] y);
		logic signed [49:0] t;
		t = $signed({1'b0, x}) * y;
		return t[31:0];
	endfunction

	logic be;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16, vld_s17;

	logic signed [16:0] p1x, p3x, p6x, p8x, p9x;

	logic signed [26:0] v1_s1;
	logic [20:0]        np_s1, np_s2, np_s3, np_s4, np_s5;
	logic signed [14:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5;
	logic signed [14:0] temp_s6, temp_s7, temp_s8;
	logic signed [53:0] vsq_s2;
	logic signed [42:0] vp5_s2, vp2_s2, vp5_s3, vp2_s3, vp5_s4, vp2_s4;
	logic [63:0]        vsqx_c;
	logic [63:0]        m6lo_s3, m3lo_s3;
	logic [31:0]        m6hi_s3, m3hi_s3;
	logic [63:0]        x6_s4, x3_s4;
	logic [63:0]        v2_s5, v1b_s5;
	logic [63:0]        e_s6, n0_s6;
	logic [63:0]        elo_s7, nlo_s7;
	logic [31:0]        ehi_s7, nhi_s7;
	logic [63:0]        esum_c;
	logic signed [30:0] v1c_s8;
	logic [63:0]        num_s8;
	logic [63:0]        ma_s9;
	logic [30:0]        mb_s9;
	div_side_t          side_s9;

	logic               div_vld;
	logic [63:0]        div_quot;
	div_side_t          div_side;

	logic [63:0]        p_s10, p_s11, p_s12, p_s13, p_s14;
	logic               inv_s10, inv_s11, inv_s12, inv_s13, inv_s14, inv_s15, inv_s16;
	logic signed [14:0] temp_s10, temp_s11, temp_s12, temp_s13, temp_s14, temp_s15;
	logic signed [14:0] temp_s16;
	logic [63:0]        q_c;
	logic [63:0]        qll_s11, p8lo_s11;
	logic [31:0]        qx_s11, p8hi_s11;
	logic [63:0]        qq_s12, w2_s12, w2_s13, w2_s14;
	logic [63:0]        p9lo_s13;
	logic [31:0]        p9hi_s13;
	logic [63:0]        w1_s14;
	logic [63:0]        s_s15;
	logic [63:0]        r_s16;
	logic [63:0]        r2_c;
	logic [19:0]        pa_c;
	logic signed [14:0] temp_s17;
	logic [19:0]        pa_s17;
	logic               inv_s17;

	// the whole back pipeline moves unless a finished result is held
	assign be    = !vld_s17 || out_ready;
	assign q_pop = be && !q_empty;

	assign p1x = {1'b0, calib.p1};
	assign p3x = {calib.p3[15], calib.p3};
	assign p6x = {calib.p6[15], calib.p6};
	assign p8x = {calib.p8[15], calib.p8};
	assign p9x = {calib.p9[15], calib.p9};

	assign vsqx_c = 64'(vsq_s2);
	assign esum_c = elo_s7 + {ehi_s7, 32'b0};
	assign q_c    = $signed(p_s10) >>> 13;
	assign r2_c   = $signed(r_s16) >>> 8;

	always_comb begin
		if (inv_s16 || r2_c[63]) begin
			pa_c = '0;
		end else if (|r2_c[63:20]) begin
			pa_c = '1;
		end else begin
			pa_c = r2_c[19:0];
		end
	end

	ptcu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (be),
		.in_valid  (vld_s9),
		.in_num    (ma_s9),
		.in_den    (mb_s9),
		.in_side   (side_s9),
		.out_valid (div_vld),
		.out_quot  (div_quot),
		.out_side  (div_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (be) begin
			vld_s1  <= !q_empty;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= div_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			// offset fine temperature and pressure complement
			v1_s1   <= 27'(q_head.fine) - V1_OFS;
			np_s1   <= P_FULL - {1'b0, q_head.raw_p};
			temp_s1 <= q_head.temp;

			vsq_s2  <= v1_s1 * v1_s1;
			vp5_s2  <= v1_s1 * calib.p5;
			vp2_s2  <= v1_s1 * calib.p2;
			np_s2   <= np_s1;
			temp_s2 <= temp_s1;

			m6lo_s3 <= mul_lo(vsqx_c[31:0], p6x);
			m6hi_s3 <= mul_hi(vsqx_c[63:32], p6x);
			m3lo_s3 <= mul_lo(vsqx_c[31:0], p3x);
			m3hi_s3 <= mul_hi(vsqx_c[63:32], p3x);
			vp5_s3  <= vp5_s2;
			vp2_s3  <= vp2_s2;
			np_s3   <= np_s2;
			temp_s3 <= temp_s2;

			// p4 shifted by 35 lands in the upper word only
			x6_s4   <= m6lo_s3 + {m6hi_s3 + {{13{calib.p4[15]}}, calib.p4, 3'b000}, 32'b0};
			x3_s4   <= m3lo_s3 + {m3hi_s3, 32'b0};
			vp5_s4  <= vp5_s3;
			vp2_s4  <= vp2_s3;
			np_s4   <= np_s3;
			temp_s4 <= temp_s3;

			v2_s5   <= x6_s4 + (64'(vp5_s4) << 17);
			v1b_s5  <= 64'($signed(x3_s4) >>> 8) + (64'(vp2_s4) << 12);
			np_s5   <= np_s4;
			temp_s5 <= temp_s4;

			e_s6    <= v1b_s5 + E_OFS;
			n0_s6   <= (64'(np_s5) << 31) - v2_s5;
			temp_s6 <= temp_s5;

			elo_s7  <= mul_lo(e_s6[31:0], p1x);
			ehi_s7  <= mul_hi(e_s6[63:32], p1x);
			nlo_s7  <= mul_lo(n0_s6[31:0], K3125);
			nhi_s7  <= mul_hi(n0_s6[63:32], K3125);
			temp_s7 <= temp_s6;

			v1c_s8  <= esum_c[63:33];
			num_s8  <= nlo_s7 + {nhi_s7, 32'b0};
			temp_s8 <= temp_s7;

			// divide magnitudes, sign restored after the divider
			ma_s9   <= num_s8[63] ? 64'd0 - num_s8 : num_s8;
			mb_s9   <= v1c_s8[30] ? 31'd0 - v1c_s8 : v1c_s8;
			side_s9 <= '{neg: num_s8[63] ^ v1c_s8[30], invalid: (v1c_s8 == '0),
				temp: temp_s8};

			p_s10    <= div_side.neg ? 64'd0 - div_quot : div_quot;
			inv_s10  <= div_side.invalid;
			temp_s10 <= div_side.temp;

			qll_s11  <= q_c[31:0] * q_c[31:0];
			qx_s11   <= q_c[31:0] * q_c[63:32];
			p8lo_s11 <= mul_lo(p_s10[31:0], p8x);
			p8hi_s11 <= mul_hi(p_s10[63:32], p8x);
			p_s11    <= p_s10;
			inv_s11  <= inv_s10;
			temp_s11 <= temp_s10;

			// square modulo 2^64: cross term counted twice
			qq_s12   <= qll_s11 + {qx_s11[30:0], 1'b0, 32'b0};
			w2_s12   <= $signed(p8lo_s11 + {p8hi_s11, 32'b0}) >>> 19;
			p_s12    <= p_s11;
			inv_s12  <= inv_s11;
			temp_s12 <= temp_s11;

			p9lo_s13 <= mul_lo(qq_s12[31:0], p9x);
			p9hi_s13 <= mul_hi(qq_s12[63:32], p9x);
			w2_s13   <= w2_s12;
			p_s13    <= p_s12;
			inv_s13  <= inv_s12;
			temp_s13 <= temp_s12;

			w1_s14   <= $signed(p9lo_s13 + {p9hi_s13, 32'b0}) >>> 25;
			w2_s14   <= w2_s13;
			p_s14    <= p_s13;
			inv_s14  <= inv_s13;
			temp_s14 <= temp_s13;

			s_s15    <= p_s14 + w1_s14 + w2_s14;
			inv_s15  <= inv_s14;
			temp_s15 <= temp_s14;

			r_s16    <= 64'($signed(s_s15) >>> 8) + (64'(calib.p7) << 4);
			inv_s16  <= inv_s15;
			temp_s16 <= temp_s15;

			pa_s17   <= pa_c;
			inv_s17  <= inv_s16;
			temp_s17 <= temp_s16;
		end
	end

	assign out_valid   = vld_s17;
	assign out_temp    = temp_s17;
	assign out_pa      = pa_s17;
	assign out_invalid = inv_s17;

endmodule

@@ hw/rtl/pressure_temperature_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// integer compensation of raw temperature and pressure conversions
// ----------------------------------------------------------------------------
// One sample pair is accepted and one result leaves per clock unless
// back-pressure stalls the pipeline. The path runs through four front stages
// that form the fine and the compensated temperature, the queue, nine stages
// of 64-bit pressure algebra, a 64-stage restoring divider that resolves one
// quotient bit per cycle while enabled, and eight stages that finish and
// saturate the pressure into the output register. The 64-bit multiplies use
// 32 by 17 bit partial products (32 by 32 for the square), each registered.
// Calibration is written over the APB port at byte addresses 0, 8, 16 and 24
// and must only change while no sample is in flight.
`include "pressure_temperature_compensation_unit_assert.svh"

module pressure_temperature_compensation_unit #(
	parameter int QUEUE_DEPTH = ptcu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // temperature_centi[14:0], pressure_pa[34:15]
	output logic [0:0]  m_axis_tuser,   // pressure_invalid[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import ptcu_pkg::*;

	localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
	localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
	localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
	localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_nine_q;
	logic        wr_en;
	calib_t      calib;

	logic               push, q_full, q_empty, q_pop;
	qent_t              push_data, q_head;
	logic signed [14:0] out_temp;
	logic [19:0]        out_pa;
	logic               out_invalid;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_nine_q <= '0;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_TEMP_CALIB: temp_calib_q <= pwdata[47:0];
				REG_PRESS_LOW:  press_low_q  <= pwdata;
				REG_PRESS_HIGH: press_high_q <= pwdata;
				REG_PRESS_NINE: press_nine_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_TEMP_CALIB: prdata = {16'b0, temp_calib_q};
			REG_PRESS_LOW:  prdata = press_low_q;
			REG_PRESS_HIGH: prdata = press_high_q;
			REG_PRESS_NINE: prdata = {48'b0, press_nine_q};
			default:        prdata = '0;
		endcase
	end

	assign calib = '{
		p9: press_nine_q,
		p8: press_high_q[63:48], p7: press_high_q[47:32],
		p6: press_high_q[31:16], p5: press_high_q[15:0],
		p4: press_low_q[63:48],  p3: press_low_q[47:32],
		p2: press_low_q[31:16],  p1: press_low_q[15:0],
		t3: temp_calib_q[47:32], t2: temp_calib_q[31:16], t1: temp_calib_q[15:0]
	};

	ptcu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.raw_t     (s_axis_tdata[19:0]),
		.raw_p     (s_axis_tdata[39:20]),
		.calib     (calib),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ptcu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	ptcu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.calib       (calib),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_temp    (out_temp),
		.out_pa      (out_pa),
		.out_invalid (out_invalid)
	);

	assign m_axis_tdata = {5'b0, out_pa, out_temp};
	assign m_axis_tuser = out_invalid;

	`PTCU_ASSERT(a_invalid_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[34:15] == '0)
	`PTCU_ASSERT(a_temp_range, clk, arst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -15'sd4000 && $signed(m_axis_tdata[14:0]) <= 15'sd8500))

endmodule
